@@ hdl/min_priority_queue_scan_top_assert.svh @@
// Assertion macros for the queue top level.
`ifndef MIN_PRIORITY_QUEUE_SCAN_TOP_ASSERT_SVH
`define MIN_PRIORITY_QUEUE_SCAN_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MPQS_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MPQS_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/mpqs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mpqs_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int KEY_W         = 32;
   localparam int TAG_W         = 16;

   typedef enum logic {
      OP_ENQ = 1'b0,
      OP_DEQ = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_TRY_DEQ,
      S_ENQ,
      S_SCAN_INIT,
      S_SCAN,
      S_SCAN_DRAIN,
      S_SHIFT_INIT,
      S_SHIFT,
      S_SHIFT_DRAIN,
      S_DEQ_DONE,
      S_RESP
   } step_type;

   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_ENQ_OK,
      COND_DEQ_OK,
      COND_PTR_ZERO,
      COND_PTR_LAST,
      COND_NO_TAIL,
      COND_OUT_BUSY
   } cond_type;

   typedef enum logic [1:0] {
      PTR_HOLD,
      PTR_LOAD_TOP,
      PTR_LOAD_NEXT,
      PTR_STEP
   } ptr_op_type;

   typedef struct packed {
      step_type   seq_next;
      cond_type   cond;
      step_type   target;
      ptr_op_type ptr_op;
      logic       accept;
      logic       latch_status;
      logic       enq_wr;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       rd;
      logic       move;
      logic       out_load;
   } ctrl_word_type;

   typedef struct packed {
      logic no_req;
      logic enq_ok;
      logic deq_ok;
      logic ptr_zero;
      logic ptr_last;
      logic no_tail;
      logic out_busy;
   } seq_flags_type;

   function automatic ctrl_word_type ucode_rom(input step_type s);
      ctrl_word_type w;
      w = '{seq_next: S_IDLE, cond: COND_NEVER, target: S_IDLE, ptr_op: PTR_HOLD,
            default: 1'b0};
      unique case (s)
         S_IDLE: begin
            w.accept = 1'b1;
            w.cond   = COND_NO_REQ;
            w.target = S_IDLE;
            w.seq_next = S_DISPATCH;
         end
         S_DISPATCH: begin
            w.latch_status = 1'b1;
            w.cond     = COND_ENQ_OK;
            w.target   = S_ENQ;
            w.seq_next = S_TRY_DEQ;
         end
         S_TRY_DEQ: begin
            w.cond     = COND_DEQ_OK;
            w.target   = S_SCAN_INIT;
            w.seq_next = S_RESP;
         end
         S_ENQ: begin
            w.enq_wr   = 1'b1;
            w.cnt_inc  = 1'b1;
            w.seq_next = S_RESP;
         end
         S_SCAN_INIT: begin
            w.ptr_op   = PTR_LOAD_TOP;
            w.seq_next = S_SCAN;
         end
         S_SCAN: begin
            w.rd       = 1'b1;
            w.ptr_op   = PTR_STEP;
            w.cond     = COND_PTR_ZERO;
            w.target   = S_SCAN_DRAIN;
            w.seq_next = S_SCAN;
         end
         S_SCAN_DRAIN: begin
            w.seq_next = S_SHIFT_INIT;
         end
         S_SHIFT_INIT: begin
            w.ptr_op   = PTR_LOAD_NEXT;
            w.cond     = COND_NO_TAIL;
            w.target   = S_DEQ_DONE;
            w.seq_next = S_SHIFT;
         end
         S_SHIFT: begin
            w.rd       = 1'b1;
            w.move     = 1'b1;
            w.ptr_op   = PTR_STEP;
            w.cond     = COND_PTR_LAST;
            w.target   = S_SHIFT_DRAIN;
            w.seq_next = S_SHIFT;
         end
         S_SHIFT_DRAIN: begin
            w.seq_next = S_DEQ_DONE;
         end
         S_DEQ_DONE: begin
            w.cnt_dec  = 1'b1;
            w.seq_next = S_RESP;
         end
         S_RESP: begin
            w.out_load = 1'b1;
            w.cond     = COND_OUT_BUSY;
            w.target   = S_RESP;
            w.seq_next = S_IDLE;
         end
         default: begin
            w.seq_next = S_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

@@ hdl/mpqs_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mpqs_seq
   import mpqs_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire seq_flags_type flags,
   output ctrl_word_type      cw
);

   step_type pc_ff;
   step_type pc_in;
   logic     take;

   always_comb begin
      cw = ucode_rom(pc_ff);
   end

   always_comb begin
      unique case (cw.cond)
         COND_NEVER:    take = 1'b0;
         COND_ALWAYS:   take = 1'b1;
         COND_NO_REQ:   take = flags.no_req;
         COND_ENQ_OK:   take = flags.enq_ok;
         COND_DEQ_OK:   take = flags.deq_ok;
         COND_PTR_ZERO: take = flags.ptr_zero;
         COND_PTR_LAST: take = flags.ptr_last;
         COND_NO_TAIL:  take = flags.no_tail;
         COND_OUT_BUSY: take = flags.out_busy;
         default:       take = 1'b0;
      endcase
      pc_in = take ? cw.target : cw.seq_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= S_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/min_priority_queue_scan_top.sv @@
// Channel | Ports                                          | Direction
// req     | req_valid/req_ready, req_op, req_key,          | in
//         | req_node_tag                                   |
// rsp     | rsp_valid/rsp_ready, rsp_status, rsp_out_key,  | out
//         | rsp_out_tag, rsp_now_empty                     |
//
// Enqueue, or dequeue on empty, or enqueue on full: dispatch, the store write when the
// enqueue has room, then the result. Successful dequeue: a newest-to-oldest key scan,
// then closing the gap by moving each entry above the minimum down one place (skipped
// with no entry above), then the fill count update and the result; both walks read one
// entry at a time through the single read port. Next accept once the result is loaded.
// Reset clears the step counter, fill count and result valid; no clearing pass.
// A result waiting for rsp_ready does not block acceptance of the next transaction;
// the sequencer holds only when a second result is ready before the first is taken.
`timescale 1ns / 1ps
`default_nettype none

`include "min_priority_queue_scan_top_assert.svh"

module min_priority_queue_scan_top
   import mpqs_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic             req_op,
   input  wire logic [KEY_W-1:0] req_key,
   input  wire logic [TAG_W-1:0] req_node_tag,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [KEY_W-1:0]      rsp_out_key,
   output logic [TAG_W-1:0]      rsp_out_tag,
   output logic                  rsp_now_empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = KEY_W + TAG_W;

   ctrl_word_type cw;
   seq_flags_type flags;

   logic [EW-1:0]    mem_ff [DEPTH];
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [EW-1:0]    wr_data;

   op_type           op_ff, op_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [TAG_W-1:0] tag_ff, tag_in;
   status_type       status_ff, status_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [AW-1:0]    ptr_ff, ptr_in;
   logic [KEY_W-1:0] best_key_ff, best_key_in;
   logic [TAG_W-1:0] best_tag_ff, best_tag_in;
   logic [AW-1:0]    best_idx_ff, best_idx_in;
   logic             first_ff, first_in;
   logic [EW-1:0]    rd_data_ff;
   logic [AW-1:0]    rd_idx_ff;
   logic             rd_vld_ff;
   logic             rd_move_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic [TAG_W-1:0] rsp_tag_ff, rsp_tag_in;
   logic             rsp_empty_ff, rsp_empty_in;

   logic             req_fire;
   logic             out_go;
   logic             full;
   logic [CW-1:0]    cnt_m1;
   logic [CW-1:0]    best_p1;
   logic [KEY_W-1:0] rd_key;
   logic [TAG_W-1:0] rd_tag;
   logic             scan_hit;

   mpqs_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .cw    (cw)
   );

   assign req_ready = cw.accept;
   assign req_fire  = req_valid & req_ready;
   assign full      = (count_ff == CW'(DEPTH));
   assign cnt_m1    = count_ff - CW'(1);
   assign best_p1   = CW'(best_idx_ff) + CW'(1);
   assign rd_key    = rd_data_ff[EW-1:TAG_W];
   assign rd_tag    = rd_data_ff[TAG_W-1:0];
   assign out_go    = cw.out_load & ~(rsp_valid_ff & ~rsp_ready);

   always_comb begin
      flags.no_req   = ~req_valid;
      flags.enq_ok   = (op_ff == OP_ENQ) & ~full;
      flags.deq_ok   = (op_ff == OP_DEQ) & (count_ff != '0);
      flags.ptr_zero = (ptr_ff == '0);
      flags.ptr_last = (ptr_ff == cnt_m1[AW-1:0]);
      flags.no_tail  = (best_p1 == count_ff);
      flags.out_busy = rsp_valid_ff & ~rsp_ready;
   end

   // entry store: enqueue writes at the fill point, gap closing writes one below the read
   always_comb begin
      wr_en   = cw.enq_wr | (rd_vld_ff & rd_move_ff);
      wr_addr = cw.enq_wr ? count_ff[AW-1:0] : rd_idx_ff - AW'(1);
      wr_data = cw.enq_wr ? {key_ff, tag_ff} : rd_data_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[ptr_ff];
      rd_idx_ff  <= ptr_ff;
   end

   always_comb begin
      op_in     = op_ff;
      key_in    = key_ff;
      tag_in    = tag_ff;
      status_in = status_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      first_in  = first_ff;
      best_key_in = best_key_ff;
      best_tag_in = best_tag_ff;
      best_idx_in = best_idx_ff;
      scan_hit  = rd_vld_ff & ~rd_move_ff & (first_ff | (rd_key < best_key_ff));

      if (req_fire) begin
         op_in  = op_type'(req_op);
         key_in = req_key;
         tag_in = req_node_tag;
      end

      if (cw.latch_status) begin
         priority if (op_ff == OP_ENQ && full) begin
            status_in = STAT_FULL;
         end else if (op_ff == OP_DEQ && count_ff == '0) begin
            status_in = STAT_EMPTY;
         end else begin
            status_in = STAT_DONE;
         end
      end

      if (cw.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cw.cnt_dec) begin
         count_in = cnt_m1;
      end

      unique case (cw.ptr_op)
         PTR_HOLD:      ptr_in = ptr_ff;
         PTR_LOAD_TOP:  ptr_in = cnt_m1[AW-1:0];
         PTR_LOAD_NEXT: ptr_in = best_p1[AW-1:0];
         PTR_STEP:      ptr_in = cw.move ? ptr_ff + AW'(1) : ptr_ff - AW'(1);
         default:       ptr_in = ptr_ff;
      endcase

      // strict compare while walking newest to oldest keeps the newest of equal keys
      if (cw.ptr_op == PTR_LOAD_TOP) begin
         first_in = 1'b1;
      end else if (rd_vld_ff & ~rd_move_ff) begin
         first_in = 1'b0;
      end
      if (scan_hit) begin
         best_key_in = rd_key;
         best_tag_in = rd_tag;
         best_idx_in = rd_idx_ff;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_empty_in  = rsp_empty_ff;
      if (out_go) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_empty_in  = (count_ff == '0);
         if (status_ff == STAT_DONE && op_ff == OP_DEQ) begin
            rsp_key_in = best_key_ff;
            rsp_tag_in = best_tag_ff;
         end else begin
            rsp_key_in = '0;
            rsp_tag_in = '0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rd_move_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_vld_ff    <= cw.rd;
         rd_move_ff   <= cw.move;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      tag_ff        <= tag_in;
      status_ff     <= status_in;
      ptr_ff        <= ptr_in;
      first_ff      <= first_in;
      best_key_ff   <= best_key_in;
      best_tag_ff   <= best_tag_in;
      best_idx_ff   <= best_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_key   = rsp_key_ff;
   assign rsp_out_tag   = rsp_tag_ff;
   assign rsp_now_empty = rsp_empty_ff;

   `MPQS_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH),
                    "fill count beyond depth")
   `MPQS_ASSERT_IMP(a_enq_room, clock, reset, cw.enq_wr, !full,
                    "enqueue write into a full store")
   `MPQS_ASSERT_IMP(a_move_range, clock, reset, rd_vld_ff && rd_move_ff,
                    rd_idx_ff != '0 && CW'(rd_idx_ff) < count_ff,
                    "gap closing outside the filled entries")
   `MPQS_ASSERT_IMP(a_empty_status, clock, reset, out_go && status_ff == STAT_EMPTY,
                    count_ff == '0, "empty status with entries held")
   `MPQS_ASSERT_NXT(a_leave_idle, clock, reset, req_fire, !req_ready,
                    "sequencer still idle after a transaction was taken")

endmodule

`default_nettype wire

@@ dv/min_priority_queue_scan_top_test.sv @@
`timescale 1ns / 1ps

module min_priority_queue_scan_top_test;
   import mpqs_pkg::*;

   localparam int QDEPTH          = DEPTH_DEFAULT;
   localparam int ITEM_TARGET     = 800;
   localparam int HOLD_OFF_AT     = 150;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int IDLE_LIMIT      = 4000;
   localparam int SETTLE_CYCLES   = 2 * QDEPTH + 10;

   typedef struct {
      op_type           op;
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
      bit               drain_first;
   } queue_req_type;

   typedef struct {
      status_type       status;
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
      logic             now_empty;
   } queue_rsp_type;

   logic             clock;
   logic             reset        = 1'b1;
   logic             req_valid    = 1'b0;
   logic             req_ready;
   logic             req_op       = OP_ENQ;
   logic [KEY_W-1:0] req_key      = '0;
   logic [TAG_W-1:0] req_node_tag = '0;
   logic             rsp_valid;
   logic             rsp_ready    = 1'b0;
   logic [1:0]       rsp_status;
   logic [KEY_W-1:0] rsp_out_key;
   logic [TAG_W-1:0] rsp_out_tag;
   logic             rsp_now_empty;

   queue_req_type    queued_requests[$];
   queue_rsp_type    due_results[$];
   logic [KEY_W-1:0] shadow_keys[$];
   logic [TAG_W-1:0] shadow_tags[$];

   int  total_reqs     = 0;
   int  gen_fill       = 0;
   bit  lead_drain     = 1'b0;
   int  accepted_reqs  = 0;
   int  checked_rsps   = 0;
   int  mismatches     = 0;
   int  idle_cycles    = 0;
   int  n_enq          = 0;
   int  n_deq          = 0;
   int  n_full         = 0;
   int  n_empty        = 0;
   int  peak_fill      = 0;
   bit  req_fire       = 1'b0;
   bit  steady_flow    = 1'b0;
   int  phase_cnt      = 0;
   int  send_gap       = 0;
   int  sink_gap       = 0;
   int  hold_off_left  = 0;
   bit  hold_off_done  = 1'b0;

   min_priority_queue_scan_top #(.DEPTH(QDEPTH)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_key       (req_key),
      .req_node_tag  (req_node_tag),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_out_key   (rsp_out_key),
      .rsp_out_tag   (rsp_out_tag),
      .rsp_now_empty (rsp_now_empty)
   );

   function automatic queue_rsp_type apply_to_shadow(op_type op, logic [KEY_W-1:0] key,
                                                     logic [TAG_W-1:0] tag);
      queue_rsp_type r;
      int            best;
      r.status = STAT_DONE;
      r.key    = '0;
      r.tag    = '0;
      if (op == OP_ENQ) begin
         if (shadow_keys.size() >= QDEPTH) begin
            r.status = STAT_FULL;
         end else begin
            shadow_keys.push_back(key);
            shadow_tags.push_back(tag);
         end
      end else if (shadow_keys.size() == 0) begin
         r.status = STAT_EMPTY;
      end else begin
         // newest first, strict compare keeps the newest of equal keys
         best = shadow_keys.size() - 1;
         for (int i = shadow_keys.size() - 2; i >= 0; i--)
            if (shadow_keys[i] < shadow_keys[best]) best = i;
         r.key = shadow_keys[best];
         r.tag = shadow_tags[best];
         shadow_keys.delete(best);
         shadow_tags.delete(best);
      end
      r.now_empty = (shadow_keys.size() == 0);
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_flow || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r < 5) return $urandom_range(0, 7);
      return $urandom;
   endfunction

   task automatic queue_request(op_type op, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
      queue_req_type rq;
      rq.op          = op;
      rq.key         = key;
      rq.tag         = tag;
      rq.drain_first = lead_drain;
      lead_drain     = 1'b0;
      queued_requests.push_back(rq);
      total_reqs++;
      if (op == OP_ENQ && gen_fill < QDEPTH) gen_fill++;
      if (op == OP_DEQ && gen_fill > 0) gen_fill--;
   endtask

   task automatic fill_burst();
      int extra;
      extra = $urandom_range(1, 4);
      while (gen_fill < QDEPTH)
         queue_request(OP_ENQ, pick_key(), TAG_W'($urandom_range(0, 65535)));
      repeat (extra) queue_request(OP_ENQ, pick_key(), TAG_W'($urandom_range(0, 65535)));
   endtask

   task automatic drain_burst();
      int extra;
      extra = $urandom_range(1, 2);
      while (gen_fill > 0) queue_request(OP_DEQ, $urandom, TAG_W'($urandom_range(0, 65535)));
      repeat (extra) queue_request(OP_DEQ, $urandom, TAG_W'($urandom_range(0, 65535)));
   endtask

   task automatic mixed_burst();
      int len;
      int p_enq;
      len   = $urandom_range(10, 30);
      p_enq = $urandom_range(30, 70);
      repeat (len) begin
         if ($urandom_range(0, 99) < p_enq)
            queue_request(OP_ENQ, pick_key(), TAG_W'($urandom_range(0, 65535)));
         else
            queue_request(OP_DEQ, $urandom, TAG_W'($urandom_range(0, 65535)));
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int r;
      // empty dequeue, extremes, ties, ignored fields on dequeue
      queue_request(OP_DEQ, '1, 16'hffff);
      queue_request(OP_ENQ, '1, 16'hffff);
      queue_request(OP_ENQ, '0, 16'h0000);
      queue_request(OP_ENQ, '0, 16'h1234);
      queue_request(OP_ENQ, 32'd5, 16'haaaa);
      queue_request(OP_ENQ, 32'd5, 16'h5555);
      queue_request(OP_DEQ, 32'h5a5a5a5a, 16'ha5a5);
      queue_request(OP_DEQ, '0, '0);
      queue_request(OP_DEQ, '1, '1);
      queue_request(OP_DEQ, '0, '0);
      queue_request(OP_DEQ, '0, '0);
      queue_request(OP_DEQ, '0, '0);
      queue_request(OP_ENQ, 32'h7fffffff, 16'h8000);
      queue_request(OP_ENQ, 32'h80000000, 16'h7fff);
      queue_request(OP_DEQ, '0, '0);
      queue_request(OP_DEQ, '0, '0);
      // full refusal, then back to empty
      lead_drain = 1'b1;
      fill_burst();
      drain_burst();
      while (total_reqs < ITEM_TARGET) begin
         lead_drain = ($urandom_range(0, 99) < 8);
         r = $urandom_range(0, 99);
         if (r < 10) fill_burst();
         else if (r < 20) drain_burst();
         else mixed_burst();
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (accepted_reqs < total_reqs) @(negedge clock);
      while (due_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Covered %0d enqueues (%0d refused as full) and %0d dequeues (%0d on empty).",
               n_enq, n_full, n_deq, n_empty);
      $display("Peak occupancy %0d of %0d; %0d results checked, %0d wrong or unexpected.",
               peak_fill, QDEPTH, checked_rsps, mismatches);
      if (mismatches == 0 && due_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   always @(negedge clock) begin
      phase_cnt++;
      if (phase_cnt == 200) begin
         phase_cnt = 0;
         steady_flow <= ($urandom_range(0, 3) == 0);
      end
   end

   always @(negedge clock) begin
      queue_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         // hold until the transaction is taken
      end else if (send_gap > 0) begin
         send_gap--;
         req_valid <= 1'b0;
      end else if (queued_requests.size() == 0) begin
         req_valid <= 1'b0;
      end else if (queued_requests[0].drain_first && due_results.size() != 0) begin
         req_valid <= 1'b0;
      end else begin
         nxt = queued_requests.pop_front();
         req_op       <= nxt.op;
         req_key      <= nxt.key;
         req_node_tag <= nxt.tag;
         req_valid    <= 1'b1;
         send_gap = pick_gap();
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_off_done && accepted_reqs >= HOLD_OFF_AT) begin
         hold_off_done = 1'b1;
         hold_off_left = HOLD_OFF_CYCLES;
         rsp_ready <= 1'b0;
      end else if (sink_gap > 0) begin
         sink_gap--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         sink_gap = pick_gap();
      end
   end

   always @(posedge clock) begin
      queue_rsp_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            accepted_reqs++;
            if (req_op == OP_ENQ) n_enq++;
            else n_deq++;
            due_results.push_back(apply_to_shadow(op_type'(req_op), req_key, req_node_tag));
            if (shadow_keys.size() > peak_fill) peak_fill = shadow_keys.size();
         end
         if (rsp_valid && rsp_ready) begin
            checked_rsps++;
            if (due_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0t] unexpected result: status %0d key %h tag %h empty %0b",
                           $realtime, rsp_status, rsp_out_key, rsp_out_tag, rsp_now_empty);
            end else begin
               want = due_results.pop_front();
               if (want.status == STAT_FULL) n_full++;
               if (want.status == STAT_EMPTY) n_empty++;
               if (rsp_status !== want.status || rsp_out_key !== want.key ||
                   rsp_out_tag !== want.tag || rsp_now_empty !== want.now_empty) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"[%0t] result %0d: expected status %0d key %h tag %h empty %0b,",
                               " got status %0d key %h tag %h empty %0b"},
                              $realtime, checked_rsps, want.status, want.key, want.tag,
                              want.now_empty, rsp_status, rsp_out_key, rsp_out_tag,
                              rsp_now_empty);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
         end
      end
   end

endmodule
